// ----- rtl/csl_pkg.sv -----
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants for the character stream lexer
// Token kinds, character codes, the punctuation table and the job record
// that travels from the classifier to the token emitter.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam logic [5:0] KIND_UNDEF  = 6'd0;
	localparam logic [5:0] KIND_LINE   = 6'd33;
	localparam logic [5:0] KIND_IDENT  = 6'd34;
	localparam logic [5:0] KIND_NUMBER = 6'd35;
	localparam logic [5:0] KIND_END    = 6'd36;

	localparam logic [7:0] CHAR_NL     = 8'h0A;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;

	localparam int NUM_PUNCT = 32;

	// Punctuation bytes in kind order; kind is the index plus one.
	localparam logic [7:0] PUNCT_BYTES [NUM_PUNCT] = '{
		8'h2B, 8'h2D, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
		8'h3A, 8'h3B, 8'h40, 8'h7E, 8'h24, 8'h25, 8'h5E, 8'h26,
		8'h2A, 8'h7C, 8'h2F, CHAR_BSLASH, 8'h22, 8'h27, 8'h3C, 8'h3E,
		8'h2C, 8'h2E, 8'h21, 8'h23, 8'h3F, 8'h3D, 8'h5F, 8'h60
	};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		RUN_NONE   = 2'd0,
		RUN_IDENT  = 2'd1,
		RUN_NUMBER = 2'd2
	} run_kind_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
		logic [7:0]  first_byte;
	} token_t;

	// Up to two tokens from one input item: a flushed run token first,
	// then the token of the byte itself (or the end token).
	typedef struct packed {
		logic   a_valid;
		token_t a;
		logic   b_valid;
		token_t b;
	} job_t;

	function automatic run_kind_t byte_class(input logic [7:0] b);
		run_kind_t c;
		c = RUN_NONE;
		if (b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
			c = RUN_IDENT;
		end else if (b inside {[8'h30:8'h39]}) begin
			c = RUN_NUMBER;
		end
		return c;
	endfunction

	function automatic logic [5:0] punct_kind(input logic [7:0] b);
		logic [5:0] k;
		k = KIND_UNDEF;
		for (int i = 0; i < NUM_PUNCT; i++) begin
			if (PUNCT_BYTES[i] == b) begin
				k = 6'(i + 1);
			end
		end
		return k;
	endfunction

endpackage

// ----- rtl/csl_front.sv -----
// ----------------------------------------------------------------------------
// csl_front: byte classifier and position tracker
// Accepts one transaction per cycle while the job queue is not full, updates
// line, column and run state, and queues the tokens that the byte causes as one job.
// ----------------------------------------------------------------------------
module csl_front #(
	parameter int POSITION_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output logic              push,
	output csl_pkg::job_t     push_job,
	input  logic              q_full
);

	localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
	localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

	function automatic logic [POSITION_WIDTH-1:0] sat_inc(
		input logic [POSITION_WIDTH-1:0] v);
		return (v == POS_MAX) ? v : v + POS_ONE;
	endfunction

	logic [POSITION_WIDTH-1:0] line_q;
	logic [POSITION_WIDTH-1:0] column_q;
	csl_pkg::run_kind_t        run_kind_q;
	logic [POSITION_WIDTH-1:0] run_start_q;
	logic [POSITION_WIDTH-1:0] run_length_q;
	logic [7:0]                run_first_q;

	logic               item_acc;
	csl_pkg::run_kind_t cls;
	logic               run_open;
	logic               extend;
	logic               is_blank;
	logic               is_nl;

	assign in_stall = q_full;
	assign item_acc = in_valid && !q_full;
	assign cls      = csl_pkg::byte_class(text_byte);
	assign run_open = (run_kind_q == csl_pkg::RUN_IDENT) ||
	                  (run_kind_q == csl_pkg::RUN_NUMBER);
	assign extend   = !end_of_text && run_open && (cls == run_kind_q);
	assign is_blank = (text_byte == csl_pkg::CHAR_SPACE) || (text_byte == csl_pkg::CHAR_TAB);
	assign is_nl    = (text_byte == csl_pkg::CHAR_NL);

	always_comb begin
		push_job.a_valid         = run_open && !extend;
		push_job.a.kind          = (run_kind_q == csl_pkg::RUN_IDENT) ?
		                           csl_pkg::KIND_IDENT : csl_pkg::KIND_NUMBER;
		push_job.a.line          = 16'(line_q);
		push_job.a.column        = 16'(run_start_q);
		push_job.a.length        = 16'(run_length_q);
		push_job.a.first_byte    = run_first_q;
		push_job.b_valid         = 1'b1;
		push_job.b.kind          = csl_pkg::punct_kind(text_byte);
		push_job.b.line          = 16'(line_q);
		push_job.b.column        = 16'(column_q);
		push_job.b.length        = 16'd1;
		push_job.b.first_byte    = text_byte;
		if (end_of_text) begin
			push_job.b.kind       = csl_pkg::KIND_END;
			push_job.b.length     = 16'd0;
			push_job.b.first_byte = 8'd0;
		end else if ((cls != csl_pkg::RUN_NONE) || is_blank) begin
			push_job.b_valid = 1'b0;
		end else if (is_nl) begin
			push_job.b.kind = csl_pkg::KIND_LINE;
			push_job.b.line = 16'(sat_inc(line_q));
		end
	end

	assign push = item_acc && (push_job.a_valid || push_job.b_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q       <= POS_ONE;
			column_q     <= POS_ONE;
			run_kind_q   <= csl_pkg::RUN_NONE;
			run_start_q  <= '0;
			run_length_q <= '0;
			run_first_q  <= '0;
		end else if (item_acc) begin
			if (end_of_text) begin
				line_q       <= POS_ONE;
				column_q     <= POS_ONE;
				run_kind_q   <= csl_pkg::RUN_NONE;
				run_start_q  <= '0;
				run_length_q <= '0;
				run_first_q  <= '0;
			end else if (extend) begin
				run_length_q <= sat_inc(run_length_q);
				column_q     <= sat_inc(column_q);
			end else if (cls != csl_pkg::RUN_NONE) begin
				run_kind_q   <= cls;
				run_start_q  <= column_q;
				run_length_q <= POS_ONE;
				run_first_q  <= text_byte;
				column_q     <= sat_inc(column_q);
			end else begin
				run_kind_q   <= csl_pkg::RUN_NONE;
				run_start_q  <= '0;
				run_length_q <= '0;
				run_first_q  <= '0;
				if (is_nl) begin
					line_q   <= sat_inc(line_q);
					column_q <= POS_ONE;
				end else begin
					column_q <= sat_inc(column_q);
				end
			end
		end
	end

endmodule

// ----- rtl/csl_fifo.sv -----
// ----------------------------------------------------------------------------
// csl_fifo: short job queue
// Show-ahead queue of jobs between the classifier and the token emitter.
// ----------------------------------------------------------------------------
module csl_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  csl_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output csl_pkg::job_t head,
	output logic          empty
);

	csl_pkg::job_t                  mem_q [csl_pkg::QUEUE_DEPTH];
	logic [csl_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [csl_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [csl_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (count_q == csl_pkg::QCNT_W'(csl_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + csl_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + csl_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + csl_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - csl_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/csl_back.sv -----
// ----------------------------------------------------------------------------
// csl_back: token emitter
// Takes jobs from the queue and presents their tokens one per transaction
// through an output register.
// ----------------------------------------------------------------------------
module csl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  csl_pkg::job_t   head,
	input  logic            q_empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output csl_pkg::token_t token,
	output logic            last_of_run
);

	logic            out_valid_q;
	csl_pkg::token_t token_q;
	logic            last_q;
	logic            phase_q;
	logic            load;
	logic            take;
	logic            sel_b;
	logic            is_last;

	assign load    = !out_valid_q || !out_stall;
	assign take    = load && !q_empty;
	assign sel_b   = phase_q || !head.a_valid;
	assign is_last = sel_b || !head.b_valid;
	assign pop     = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= !q_empty;
			end
			if (take) begin
				phase_q <= !is_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			token_q <= sel_b ? head.b : head.a;
			last_q  <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign token       = token_q;
	assign last_of_run = last_q;

endmodule

// ----- rtl/char_stream_lexer.sv -----
// A token passes from the classifier through the job queue and the emitter's output
// register before it is on the outputs.
// Throughput: one input transaction per cycle while the four-entry job queue has room;
// an item that yields two tokens is emitted as two output transactions, so a stream of
// such items is limited by the output side. A full queue stalls the input.
// Reset (arst_n low, asynchronous) sets line and column to 1 and empties the queue.
// ----------------------------------------------------------------------------
// char_stream_lexer: streaming byte lexer with line and column tracking
// Classifies one text byte per transaction and emits punctuation, line,
// identifier, number, undefined and end tokens with their positions.
// ----------------------------------------------------------------------------
module char_stream_lexer #(
	parameter int POSITION_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic [15:0] token_length,
	output logic [7:0]  token_first_byte,
	output logic        last_of_run
);

	// The front end owns all lexer state and turns each accepted byte into
	// no job or a job of one or two tokens. A run is only reported when a byte of
	// another class (or the end transaction) closes it, so the run token and
	// the closing byte's own token share one job.
	logic            push;
	csl_pkg::job_t   push_job;
	logic            q_full;
	logic            pop;
	csl_pkg::job_t   head;
	logic            q_empty;
	csl_pkg::token_t token;

	csl_front #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.push        (push),
		.push_job    (push_job),
		.q_full      (q_full)
	);

	// The queue decouples the classifier from the output side so that a
	// stalled consumer does not immediately stall the byte stream.
	csl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// The back end walks through the tokens of the head job and marks the
	// final token of each job with last_of_run.
	csl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token       (token),
		.last_of_run (last_of_run)
	);

	assign token_kind       = token.kind;
	assign token_line       = token.line;
	assign token_column     = token.column;
	assign token_length     = token.length;
	assign token_first_byte = token.first_byte;

`ifndef SYNTHESIS
	// The end token is always the final token of its transaction.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (token_kind == csl_pkg::KIND_END)) |-> last_of_run)
		else $error("end token without last_of_run");

	// Every token except the end token covers at least one byte.
	a_length_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (token_kind != csl_pkg::KIND_END)) |-> (token_length != 16'd0))
		else $error("zero-length token");

	// A line token always carries the newline byte and is the last token.
	a_line_token: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (token_kind == csl_pkg::KIND_LINE)) |->
		((token_first_byte == csl_pkg::CHAR_NL) && last_of_run))
		else $error("malformed line token");
`endif

endmodule
